// ===== sv/stq_pkg.sv =====
`timescale 1ns / 1ps
package stq_pkg;
    localparam int CAPACITY_DEF  = 32;
    localparam int TIME_BITS_DEF = 32;
    localparam int MAX_OUT       = 32;

    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_ADJUST = 2'd1,
        FN_DELETE = 2'd2,
        FN_TICK   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_FULL     = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_DUP      = 3'd3,
        ST_EXPIRED  = 3'd4,
        ST_NONE     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_FIND_CHK,
        S_DECIDE,
        S_REM,
        S_INS_SRCH,
        S_INS_SHIFT,
        S_INS_WR,
        S_TICK_RD,
        S_TICK_CHK,
        S_TICK_REM,
        S_OUT
    } state_t;

    typedef struct packed {
        logic clr_idx;
        logic idx_inc;
        logic idx_dec;
        logic rd_idx;
        logic rd_idx_p1;
        logic rd_idx_m1;
        logic wr_shift;
        logic wr_new;
        logic cnt_inc;
        logic cnt_dec;
        logic save_pos;
        logic idx_from_pos;
        logic idx_from_cnt;
    } dp_cmd_t;

    typedef struct packed {
        logic idx_lt_cnt;
        logic idx_p1_lt_cnt;
        logic idx_gt_pos;
        logic hit;
        logic le_key;
        logic le_now;
        logic full;
        logic empty;
    } dp_stat_t;
endpackage

// ===== sv/stq_datapath.sv =====
`timescale 1ns / 1ps
module stq_datapath
    import stq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [15:0]          in_handle,
    input  logic [TIME_BITS-1:0] in_expire,
    input  logic [TIME_BITS-1:0] in_now,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic [15:0]          rd_handle
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [TIME_BITS-1:0] exp_mem [CAPACITY];
    logic [15:0]          hdl_mem [CAPACITY];

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg;
    logic [15:0]          key_h_reg;
    logic [TIME_BITS-1:0] key_t_reg, now_reg;
    logic [TIME_BITS-1:0] rd_exp_reg;
    logic [15:0]          rd_hdl_reg;
    logic [CW-1:0]        rd_addr;
    logic [CW-1:0]        idx_p1, idx_m1;

    assign idx_p1 = idx_reg + CW'(1);
    assign idx_m1 = idx_reg - CW'(1);

    always_comb
    begin
        rd_addr = idx_reg;
        if (cmd.rd_idx_p1)
        begin
            rd_addr = idx_p1;
        end
        else if (cmd.rd_idx_m1)
        begin
            rd_addr = idx_m1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_idx || cmd.rd_idx_p1 || cmd.rd_idx_m1)
        begin
            rd_exp_reg <= exp_mem[rd_addr[AW-1:0]];
            rd_hdl_reg <= hdl_mem[rd_addr[AW-1:0]];
        end
        if (cmd.wr_shift)
        begin
            exp_mem[idx_reg[AW-1:0]] <= rd_exp_reg;
            hdl_mem[idx_reg[AW-1:0]] <= rd_hdl_reg;
        end
        else if (cmd.wr_new)
        begin
            exp_mem[idx_reg[AW-1:0]] <= key_t_reg;
            hdl_mem[idx_reg[AW-1:0]] <= key_h_reg;
        end
        if (load)
        begin
            key_h_reg <= in_handle;
            key_t_reg <= in_expire;
            now_reg   <= in_now;
        end
        if (cmd.save_pos)
        begin
            pos_reg <= idx_reg;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.clr_idx)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_from_pos)
        begin
            idx_next = pos_reg;
        end
        else if (cmd.idx_from_cnt)
        begin
            idx_next = cnt_reg;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_p1;
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_m1;
        end
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    assign stat.idx_lt_cnt    = idx_reg < cnt_reg;
    assign stat.idx_p1_lt_cnt = idx_p1 < cnt_reg;
    assign stat.idx_gt_pos    = idx_reg > pos_reg;
    assign stat.hit           = rd_hdl_reg == key_h_reg;
    assign stat.le_key        = rd_exp_reg <= key_t_reg;
    assign stat.le_now        = rd_exp_reg <= now_reg;
    assign stat.full          = cnt_reg >= CW'(CAPACITY);
    assign stat.empty         = cnt_reg == '0;
    assign rd_handle          = rd_hdl_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("count overflow");
    a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> !stat.full)
        else $error("insert into full table");
    a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> !stat.empty)
        else $error("remove from empty table");
endmodule

// ===== sv/stq_ctrl.sv =====
`timescale 1ns / 1ps
module stq_ctrl
    import stq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  in_func,
    output logic        load,
    output dp_cmd_t     cmd,
    input  dp_stat_t    stat,
    input  logic [15:0] rd_handle,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  o_status,
    output logic [15:0] o_handle,
    output logic        o_last
);
    localparam int NW = $clog2(MAX_OUT + 1);

    state_t state_reg, state_next;
    func_t  func_reg, func_next;
    logic   found_reg, found_next;
    logic [NW-1:0] n_reg, n_next;
    logic [2:0]  st_reg, st_next;
    logic [15:0] oh_reg, oh_next;
    logic        ol_reg, ol_next;
    logic        tick_more_reg, tick_more_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            func_reg      <= FN_ADD;
            found_reg     <= 1'b0;
            n_reg         <= '0;
            tick_more_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            found_reg     <= found_next;
            n_reg         <= n_next;
            tick_more_reg <= tick_more_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        oh_reg <= oh_next;
        ol_reg <= ol_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        found_next     = found_reg;
        n_next         = n_reg;
        tick_more_next = tick_more_reg;
        st_next        = st_reg;
        oh_next        = oh_reg;
        ol_next        = ol_reg;
        cmd            = '0;
        load           = 1'b0;
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    load           = 1'b1;
                    func_next      = func_t'(in_func);
                    found_next     = 1'b0;
                    n_next         = '0;
                    tick_more_next = 1'b0;
                    cmd.clr_idx    = 1'b1;
                    state_next  = (func_t'(in_func) == FN_TICK) ? S_TICK_RD : S_FIND;
                end
            end
            S_FIND:
            begin
                if (stat.idx_lt_cnt)
                begin
                    cmd.rd_idx = 1'b1;
                    state_next = S_FIND_CHK;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_FIND_CHK:
            begin
                if (stat.hit)
                begin
                    found_next   = 1'b1;
                    cmd.save_pos = 1'b1;
                    state_next   = S_DECIDE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_FIND;
                end
            end
            S_DECIDE:
            begin
                ol_next = 1'b1;
                oh_next = '0;
                st_next = ST_DONE;
                priority if (func_reg == FN_ADD)
                begin
                    if (found_reg)
                    begin
                        st_next    = ST_DUP;
                        state_next = S_OUT;
                    end
                    else if (stat.full)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.clr_idx = 1'b1;
                        state_next  = S_INS_SRCH;
                    end
                end
                else if (!found_reg)
                begin
                    st_next    = ST_NOTFOUND;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.idx_from_pos = 1'b1;
                    state_next       = S_REM;
                end
            end
            S_REM:
            begin
                // compact: slot idx takes slot idx+1, read one ahead
                if (stat.idx_p1_lt_cnt)
                begin
                    cmd.rd_idx_p1 = 1'b1;
                    state_next    = S_TICK_REM;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    if (func_reg == FN_TICK)
                    begin
                        state_next  = S_TICK_RD;
                        cmd.clr_idx = 1'b1;
                    end
                    else if (func_reg == FN_ADJUST)
                    begin
                        cmd.clr_idx = 1'b1;
                        state_next  = S_INS_SRCH;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_TICK_REM:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_REM;
            end
            S_INS_SRCH:
            begin
                if (stat.idx_lt_cnt)
                begin
                    cmd.rd_idx = 1'b1;
                    state_next = S_INS_SHIFT;
                end
                else
                begin
                    cmd.save_pos     = 1'b1;
                    cmd.idx_from_cnt = 1'b1;
                    found_next       = 1'b0;
                    state_next       = S_INS_WR;
                end
            end
            S_INS_SHIFT:
            begin
                if (stat.le_key)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_INS_SRCH;
                end
                else
                begin
                    cmd.save_pos     = 1'b1;
                    cmd.idx_from_cnt = 1'b1;
                    found_next       = 1'b0;
                    state_next       = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                // open a gap from the top down, then drop the new entry in
                if (stat.idx_gt_pos)
                begin
                    cmd.rd_idx_m1 = 1'b1;
                    state_next    = S_INS_WR;
                    if (found_reg)
                    begin
                        cmd.wr_shift = 1'b1;
                        cmd.idx_dec  = 1'b1;
                        found_next   = 1'b0;
                    end
                    else
                    begin
                        found_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.wr_new  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_TICK_RD:
            begin
                if (!stat.empty && (n_reg < NW'(MAX_OUT)))
                begin
                    cmd.rd_idx = 1'b1;
                    state_next = S_TICK_CHK;
                end
                else if (tick_more_reg)
                begin
                    ol_next        = 1'b1;
                    tick_more_next = 1'b0;
                    state_next     = S_OUT;
                end
                else
                begin
                    st_next    = ST_NONE;
                    oh_next    = '0;
                    ol_next    = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_TICK_CHK:
            begin
                // a held expired item goes out once the next head is known
                if (stat.le_now)
                begin
                    if (tick_more_reg)
                    begin
                        tick_more_next = 1'b0;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        st_next        = ST_EXPIRED;
                        oh_next        = rd_handle;
                        ol_next        = 1'b0;
                        n_next         = n_reg + NW'(1);
                        tick_more_next = 1'b1;
                        state_next     = S_REM;
                    end
                end
                else if (tick_more_reg)
                begin
                    ol_next        = 1'b1;
                    tick_more_next = 1'b0;
                    state_next     = S_OUT;
                end
                else
                begin
                    st_next    = ST_NONE;
                    oh_next    = '0;
                    ol_next    = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ol_reg ? S_IDLE : S_TICK_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign o_status = st_reg;
    assign o_handle = oh_reg;
    assign o_last   = ol_reg;
endmodule

// ===== sv/sorted_timer_queue_top.sv =====
`timescale 1ns / 1ps
// channel | dir | fields
// s_axis  | in  | tdata: func[1:0] handle[17:2] expire[49:18] now[81:50]
// m_axis  | out | tdata: status[2:0] expired_handle[18:3]; tlast: last
// One item at a time; add/adjust/delete walk the table entry by entry, and
// tick runs a compaction shift and look-ahead for each expired entry.
// Reset clears the entry count, not the table; table contents are undefined.
// A stalled result holds the block; no new item is taken until it drains.
module sorted_timer_queue_top
    import stq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // func, handle, expire, now
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // status, expired_handle
    output logic        m_axis_tlast
);
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic        load;
    logic [15:0] rd_handle;
    logic [2:0]  o_status;
    logic [15:0] o_handle;
    logic        o_last;
    logic        int_valid;
    logic        int_ready;

    stq_datapath #(.CAPACITY(CAPACITY), .TIME_BITS(TIME_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .in_handle (s_axis_tdata[17:2]),
        .in_expire (TIME_BITS'(s_axis_tdata[49:18])),
        .in_now    (TIME_BITS'(s_axis_tdata[81:50])),
        .cmd       (cmd),
        .stat      (stat),
        .rd_handle (rd_handle)
    );

    stq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .in_func  (s_axis_tdata[1:0]),
        .load     (load),
        .cmd      (cmd),
        .stat     (stat),
        .rd_handle(rd_handle),
        .m_tvalid (int_valid),
        .m_tready (int_ready),
        .o_status (o_status),
        .o_handle (o_handle),
        .o_last   (o_last)
    );

    assign m_axis_tvalid = int_valid;
    assign int_ready     = m_axis_tready;
    assign m_axis_tdata  = {5'd0, o_handle, o_status};
    assign m_axis_tlast  = o_last;
endmodule

// ===== tb/sorted_timer_queue_top_tb.sv =====
`timescale 1ns / 1ps
module sorted_timer_queue_top_tb;
    import stq_pkg::*;

    typedef struct {
        status_t     status;
        logic [15:0] handle;
        logic        last;
    } timer_result_t;

    class timer_scoreboard;
        logic [31:0]   expiry_q[$];
        logic [15:0]   handle_q[$];
        timer_result_t pending[$];
        int            errors = 0;

        function int find_handle(logic [15:0] h);
            foreach (handle_q[i])
                if (handle_q[i] == h) return i;
            return -1;
        endfunction

        function void place(logic [15:0] h, logic [31:0] t);
            int pos;
            pos = 0;
            while (pos < expiry_q.size() && expiry_q[pos] <= t) pos++;
            expiry_q.insert(pos, t);
            handle_q.insert(pos, h);
        endfunction

        function void push(status_t s, logic [15:0] h, logic l);
            timer_result_t r;
            r.status = s;
            r.handle = h;
            r.last = l;
            pending.push_back(r);
        endfunction

        function void note_item(func_t fn, logic [15:0] h, logic [31:0] t, logic [31:0] now);
            int pos;
            int n;
            pos = find_handle(h);
            case (fn)
                FN_ADD:
                    if (pos >= 0) push(ST_DUP, 0, 1);
                    else if (expiry_q.size() >= CAPACITY_DEF) push(ST_FULL, 0, 1);
                    else
                    begin
                        place(h, t);
                        push(ST_DONE, 0, 1);
                    end
                FN_ADJUST, FN_DELETE:
                    if (pos < 0) push(ST_NOTFOUND, 0, 1);
                    else
                    begin
                        expiry_q.delete(pos);
                        handle_q.delete(pos);
                        if (fn == FN_ADJUST) place(h, t);
                        push(ST_DONE, 0, 1);
                    end
                default:
                begin
                    n = 0;
                    while (n < MAX_OUT && expiry_q.size() > 0 && expiry_q[0] <= now)
                    begin
                        push(ST_EXPIRED, handle_q[0], 0);
                        expiry_q.delete(0);
                        handle_q.delete(0);
                        n++;
                    end
                    if (n == 0) push(ST_NONE, 0, 1);
                    else pending[pending.size() - 1].last = 1;
                end
            endcase
        endfunction

        function void check_result(logic [23:0] data, logic lst);
            timer_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result data=%h last=%b", $time, data, lst);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[2:0] !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, data[2:0]);
                errors++;
            end
            if (data[18:3] !== e.handle)
            begin
                $display("%0t: handle expected %h actual %h", $time, e.handle, data[18:3]);
                errors++;
            end
            if (data[23:19] !== 5'd0)
            begin
                $display("%0t: pad expected 0 actual %h", $time, data[23:19]);
                errors++;
            end
            if (lst !== e.last)
            begin
                $display("%0t: last expected %b actual %b", $time, e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    timer_scoreboard sb;
    int  idle_pct;
    bit  hold_off;
    int  quiet_cycles;
    logic [15:0] used_handles[$];

    sorted_timer_queue_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        sb = new();
        idle_pct = 34;
        hold_off = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        rst_n = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
        if (rst_n)
            m_axis_tready <= !hold_off && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("sorted_timer_queue_top_tb failed");
            $finish;
        end
    end

    initial quiet_cycles = 0;

    task automatic send_item(func_t fn, logic [15:0] h, logic [31:0] t, logic [31:0] now);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tdata <= {6'd0, now, t, h, fn};
        s_axis_tvalid <= 1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_item(fn, h, t, now);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_handle();
        if (used_handles.size() > 0 && $urandom_range(3) != 0)
            return used_handles[$urandom_range(used_handles.size() - 1)];
        return 16'($urandom_range(63));
    endfunction

    task automatic random_phase(int count, int max_time);
        func_t fn;
        logic [15:0] h;
        logic [31:0] t;
        for (int i = 0; i < count; i++)
        begin
            h = pick_handle();
            if ($urandom_range(9) == 0) h = 16'($urandom);
            t = $urandom_range(max_time);
            if ($urandom_range(19) == 0) t = $urandom;
            case ($urandom_range(9))
                0, 1, 2, 3: fn = FN_ADD;
                4, 5:       fn = FN_ADJUST;
                6:          fn = FN_DELETE;
                default:    fn = FN_TICK;
            endcase
            if (fn == FN_ADD) used_handles.push_back(h);
            send_item(fn, h, t, $urandom_range(max_time));
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        send_item(FN_TICK, 0, 0, 32'hFFFF_FFFF);
        send_item(FN_DELETE, 16'hFFFF, 0, 0);
        send_item(FN_ADJUST, 16'h1234, 5, 0);
        send_item(FN_ADD, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send_item(FN_ADD, 16'h0000, 32'd0, 0);
        send_item(FN_ADD, 16'hFFFF, 32'd7, 0);
        send_item(FN_ADD, 16'hAAAA, 32'd10, 0);
        send_item(FN_ADD, 16'h5555, 32'd10, 0);
        send_item(FN_ADJUST, 16'hAAAA, 32'd10, 0);
        send_item(FN_ADJUST, 16'hFFFF, 32'd3, 0);
        send_item(FN_DELETE, 16'h0000, 0, 0);
        send_item(FN_TICK, 0, 0, 32'd2);
        send_item(FN_TICK, 0, 0, 32'd10);
        send_item(FN_TICK, 0, 0, 32'hFFFF_FFFF);
        for (int i = 0; i < 33; i++)
            send_item(FN_ADD, 16'(16'h8000 + i), 32'd100, 0);
        send_item(FN_TICK, 0, 0, 32'hFFFF_FFFF);
        drain();

        random_phase(150, 1000);
        drain();

        idle_pct = 0;
        random_phase(80, 400);
        idle_pct = 34;

        fork
        begin
            hold_off = 1;
            repeat (400) @(posedge clk);
            hold_off = 0;
        end
        random_phase(40, 300);
        join
        drain();

        random_phase(150, 200);
        send_item(FN_TICK, 0, 0, 32'hFFFF_FFFF);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("sorted_timer_queue_top_tb passed");
        else
            $display("sorted_timer_queue_top_tb failed");
        $finish;
    end
endmodule

// ===== files.f =====
sv/stq_pkg.sv
sv/stq_datapath.sv
sv/stq_ctrl.sv
sv/sorted_timer_queue_top.sv
tb/sorted_timer_queue_top_tb.sv
